// File: rtl/dwma_pkg.sv
// ----------------------------------------------------------------------------
// dwma_pkg
// Shared types and constants for the dual window moving average block.
// ----------------------------------------------------------------------------
package dwma_pkg;

    // fixed field widths on the stream ports
    localparam int SAMPLE_W  = 12;
    localparam int AVG_W     = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

    // default configuration
    localparam int DEF_SHORT_WINDOW = 16;
    localparam int DEF_LONG_WINDOW  = 32;
    localparam int DEF_SAMPLE_BITS  = 12;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_UPD   = 5'b00010,
        ST_DIV_S = 5'b00100,
        ST_DIV_L = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    // sequencer strobes to each window
    typedef struct packed {
        logic rd;
        logic upd;
    } win_ctrl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/dwma_divider.sv
// ----------------------------------------------------------------------------
// dwma_divider
// Shared restoring divider, one quotient bit per cycle. The quotient is known
// to fit in QW bits, so only the low QW steps are run.
// ----------------------------------------------------------------------------
module dwma_divider #(
    parameter int DW  = 17,
    parameter int DVW = 6,
    parameter int QW  = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [DVW-1:0]       divisor,
    output dwma_pkg::div_stat_t  stat,
    output logic [QW-1:0]        quotient
);

    localparam int CW = $clog2(QW);

    logic [DVW-1:0] rem_reg, rem_next;
    logic [QW-1:0]  quo_reg, quo_next;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // upper dividend bits are below the divisor, so they seed the remainder
            rem_next  = DVW'(dividend >> QW);
            quo_next  = dividend[QW-1:0];
            cnt_next  = CW'(QW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dvs_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// File: rtl/dwma_window.sv
// ----------------------------------------------------------------------------
// dwma_window
// One boxcar window: sample ring, write position, running sum and full flag.
// Hands the sum and the current divisor to the shared divider.
// ----------------------------------------------------------------------------
module dwma_window #(
    parameter int WINDOW = 16,
    parameter int SB     = 12,
    parameter int DW     = 17,
    parameter int DVW    = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dwma_pkg::win_ctrl_t  ctrl,
    input  logic [SB-1:0]        sample,
    output logic [DW-1:0]        total,
    output logic [DVW-1:0]       divisor
);

    localparam int PW = $clog2(WINDOW);
    localparam int TW = SB + $clog2(WINDOW);

    logic [SB-1:0] ring_mem [WINDOW];
    logic [SB-1:0] rd_reg;
    logic [SB-1:0] old_val;
    logic [PW-1:0] pos_reg, pos_next;
    logic [TW-1:0] total_reg, total_next;
    logic          full_reg, full_next;

    // entries past the write position are unwritten until the first wrap
    assign old_val = full_reg ? rd_reg : '0;

    always_comb begin
        pos_next   = pos_reg;
        total_next = total_reg;
        full_next  = full_reg;
        if (ctrl.upd) begin
            total_next = total_reg - TW'(old_val) + TW'(sample);
            if (pos_reg == PW'(WINDOW - 1)) begin
                pos_next  = '0;
                full_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            total_reg <= '0;
            full_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rd) begin
            rd_reg <= ring_mem[pos_reg];
        end
        if (ctrl.upd) begin
            ring_mem[pos_reg] <= sample;
        end
    end

    assign total   = DW'(total_reg);
    assign divisor = full_reg ? DVW'(WINDOW) : DVW'(pos_reg);

endmodule

// File: rtl/dual_window_moving_average.sv
// ----------------------------------------------------------------------------
// dual_window_moving_average
// Two boxcar moving averages of one converter sample stream.
// ----------------------------------------------------------------------------
// Each accepted sample updates a short and a long window and yields one word
// with both truncated means; during warm-up a window divides by the number of
// samples seen so far. One sample is processed at a time: s_axis_tready is
// high only while the block is idle, and the spacing of samples is set by the
// single shared divider that produces one quotient bit per cycle, first for
// the short and then for the long window. The result sits in an output
// register, so the next sample is taken while a result still waits on
// m_axis_tready.
module dual_window_moving_average #(
    parameter int SHORT_WINDOW = dwma_pkg::DEF_SHORT_WINDOW,
    parameter int LONG_WINDOW  = dwma_pkg::DEF_LONG_WINDOW,
    parameter int SAMPLE_BITS  = dwma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dwma_pkg::S_TDATA_W-1:0] s_axis_tdata,   // sample, zero pad
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dwma_pkg::M_TDATA_W-1:0] m_axis_tdata    // avg_short, avg_long
);

    localparam int MAX_WIN = dwma_pkg::max_int(SHORT_WINDOW, LONG_WINDOW);
    localparam int DW      = SAMPLE_BITS + $clog2(MAX_WIN);
    localparam int DVW     = $clog2(MAX_WIN + 1);

    dwma_pkg::state_t    state_reg, state_next;
    dwma_pkg::win_ctrl_t win_ctrl;
    dwma_pkg::div_stat_t div_stat;

    logic [SAMPLE_BITS-1:0]     samp_reg;
    logic [DW-1:0]              short_total, long_total, dividend;
    logic [DVW-1:0]             short_div, long_div, divisor;
    logic [SAMPLE_BITS-1:0]     quotient;
    logic [dwma_pkg::AVG_W-1:0] avg_s_reg;
    logic [dwma_pkg::M_TDATA_W-1:0] out_data_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       div_start_reg, div_start_next;
    logic                       s_accept;
    logic                       out_load;

    assign s_axis_tready = (state_reg == dwma_pkg::ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == dwma_pkg::ST_OUT) && (!out_valid_reg || m_axis_tready);

    assign win_ctrl.rd  = s_accept;
    assign win_ctrl.upd = (state_reg == dwma_pkg::ST_UPD);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dwma_pkg::ST_IDLE:  if (s_accept) state_next = dwma_pkg::ST_UPD;
            dwma_pkg::ST_UPD:   state_next = dwma_pkg::ST_DIV_S;
            dwma_pkg::ST_DIV_S: if (div_stat.done) state_next = dwma_pkg::ST_DIV_L;
            dwma_pkg::ST_DIV_L: if (div_stat.done) state_next = dwma_pkg::ST_OUT;
            dwma_pkg::ST_OUT:   if (out_load) state_next = dwma_pkg::ST_IDLE;
            default:            state_next = dwma_pkg::ST_IDLE;
        endcase
    end

    // kick the divider once the sums are settled, then again for the long window
    assign div_start_next = (state_reg == dwma_pkg::ST_UPD)
                         || ((state_reg == dwma_pkg::ST_DIV_S) && div_stat.done);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dwma_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            div_start_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            div_start_reg <= div_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            samp_reg <= SAMPLE_BITS'(s_axis_tdata[dwma_pkg::SAMPLE_W-1:0]);
        end
        if ((state_reg == dwma_pkg::ST_DIV_S) && div_stat.done) begin
            avg_s_reg <= dwma_pkg::AVG_W'(quotient);
        end
        if (out_load) begin
            out_data_reg <= {dwma_pkg::AVG_W'(quotient), avg_s_reg};
        end
    end

    dwma_window #(
        .WINDOW (SHORT_WINDOW),
        .SB     (SAMPLE_BITS),
        .DW     (DW),
        .DVW    (DVW)
    ) u_short (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .sample  (samp_reg),
        .total   (short_total),
        .divisor (short_div)
    );

    dwma_window #(
        .WINDOW (LONG_WINDOW),
        .SB     (SAMPLE_BITS),
        .DW     (DW),
        .DVW    (DVW)
    ) u_long (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (win_ctrl),
        .sample  (samp_reg),
        .total   (long_total),
        .divisor (long_div)
    );

    assign dividend = (state_reg == dwma_pkg::ST_DIV_S) ? short_total : long_total;
    assign divisor  = (state_reg == dwma_pkg::ST_DIV_S) ? short_div : long_div;

    dwma_divider #(
        .DW  (DW),
        .DVW (DVW),
        .QW  (SAMPLE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (dividend),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // an accepted word always moves on to the window update
    a_accept_to_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == dwma_pkg::ST_UPD))
        else $error("accepted word did not reach window update");

    // divider only finishes while the sequencer waits on it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == dwma_pkg::ST_DIV_S || state_reg == dwma_pkg::ST_DIV_L))
        else $error("divider finished outside a divide state");

    // divider is never restarted while still running
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start_reg |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // a new result only appears from the output state
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == dwma_pkg::ST_OUT))
        else $error("result raised outside output state");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual window moving average block.
// ----------------------------------------------------------------------------
// Samples go in on the slave stream with random gaps, and the result stream
// stalls at random. Each accepted sample runs through a bench copy of both
// boxcar windows; the two means it yields are queued and compared against
// the next result word. Warm-up after reset, full-scale runs, random data,
// slow ramps and gapless streaming are covered in turn.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W    = dwma_pkg::SAMPLE_W;
    localparam int AVG_W       = dwma_pkg::AVG_W;
    localparam int S_TDATA_W   = dwma_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = dwma_pkg::M_TDATA_W;
    localparam int SHORT_LEN   = dwma_pkg::DEF_SHORT_WINDOW;
    localparam int LONG_LEN    = dwma_pkg::DEF_LONG_WINDOW;
    localparam int RING_DEPTH  = (SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN;
    localparam int SHORT_SIDE  = 0;
    localparam int LONG_SIDE   = 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [AVG_W-1:0] avg_long;
        logic [AVG_W-1:0] avg_short;
    } avg_pair_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // sample, zero pad
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;         // avg_short, avg_long

    // bench copy of both windows, indexed by SHORT_SIDE / LONG_SIDE
    logic [SAMPLE_W-1:0] win_ring [0:1][0:RING_DEPTH-1];
    int unsigned         win_pos   [0:1];
    int unsigned         win_total [0:1];
    bit                  win_full  [0:1];

    avg_pair_t expected_avgs[$];
    int        mismatches  = 0;
    bit        steady_flow = 1'b0;

    dual_window_moving_average dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    function automatic logic [AVG_W-1:0] advance_window(input int side,
                                                        input logic [SAMPLE_W-1:0] value);
        int unsigned len;
        int unsigned slot;
        len  = (side == SHORT_SIDE) ? SHORT_LEN : LONG_LEN;
        slot = win_pos[side];
        win_total[side] = win_total[side] - win_ring[side][slot] + value;
        win_ring[side][slot] = value;
        slot++;
        // wrapping to zero marks the window full, so warm-up never divides by 0
        if (slot == len) begin
            slot = 0;
            win_full[side] = 1'b1;
        end
        win_pos[side] = slot;
        if (win_full[side])
            return AVG_W'(win_total[side] / len);
        else
            return AVG_W'(win_total[side] / slot);
    endfunction

    function automatic void predict_means(input logic [SAMPLE_W-1:0] value);
        avg_pair_t pair;
        pair.avg_short = advance_window(SHORT_SIDE, value);
        pair.avg_long  = advance_window(LONG_SIDE, value);
        expected_avgs.push_back(pair);
    endfunction

    // returns at the rising edge where the word was taken
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = steady_flow ? 0 : gap_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(value);
        do @(posedge aclk); while (!s_axis_tready);
        predict_means(value);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (expected_avgs.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input avg_pair_t want,
                                   input avg_pair_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected short %0d long %0d, got short %0d long %0d",
                     $realtime, what, want.avg_short, want.avg_long,
                     got.avg_short, got.avg_long);
    endtask

    // warm-up divisors, both extremes and every sample bit
    task automatic test_warmup();
        logic [SAMPLE_W-1:0] seq [$];
        seq = '{12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'h800, 12'h7FF,
                12'hAAA, 12'h555};
        for (int b = 0; b < SAMPLE_W; b++)
            seq.push_back(SAMPLE_W'(1) << b);
        foreach (seq[i])
            send_sample(seq[i]);
    endtask

    // long full-scale run saturates both totals, then falls back to zero
    task automatic test_full_scale();
        repeat (40)
            send_sample(($urandom_range(0, 7) == 0) ? 12'hFFE : 12'hFFF);
        repeat (40)
            send_sample(($urandom_range(0, 7) == 0) ? 12'h001 : 12'h000);
    endtask

    task automatic test_random_samples();
        repeat (200)
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        // let every result out before carrying on
        drain_results();
        repeat (200)
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    endtask

    // slowly drifting level with an occasional step
    task automatic test_slow_ramp();
        int level;
        level = $urandom_range(0, 4095);
        repeat (100) begin
            if ($urandom_range(0, 19) == 0)
                level = $urandom_range(0, 4095);
            else
                level = level + $urandom_range(0, 16) - 8;
            if (level < 0)
                level = 0;
            if (level > 4095)
                level = 4095;
            send_sample(SAMPLE_W'(level));
        end
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        repeat (60)
            send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        steady_flow = 1'b0;
    endtask

    initial begin : result_stall
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    always @(posedge aclk) begin : check_result
        avg_pair_t got;
        avg_pair_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.avg_short = m_axis_tdata[AVG_W-1:0];
            got.avg_long  = m_axis_tdata[2*AVG_W-1:AVG_W];
            if (expected_avgs.size() == 0) begin
                report_mismatch("unexpected word", '0, got);
            end else begin
                want = expected_avgs.pop_front();
                if (got.avg_short !== want.avg_short || got.avg_long !== want.avg_long)
                    report_mismatch("mean mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        for (int side = 0; side < 2; side++) begin
            for (int i = 0; i < RING_DEPTH; i++)
                win_ring[side][i] = '0;
            win_pos[side]   = 0;
            win_total[side] = 0;
            win_full[side]  = 1'b0;
        end
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_warmup();
        test_full_scale();
        test_random_samples();
        test_slow_ramp();
        test_back_to_back();

        drain_results();
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/dwma_pkg.sv
rtl/dwma_divider.sv
rtl/dwma_window.sv
rtl/dual_window_moving_average.sv
verif/tb.sv
